// ===== hdl/hft_pkg.sv =====
package hft_pkg;

  // fixed field widths
  localparam int SYM_W    = 8;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 4;
  localparam int STATUS_W = 2;

  // serialization marker for a leaf; its symbol byte follows
  localparam logic [SYM_W-1:0] LEAF_MARK = 8'h31;

  // most code bits in one word
  localparam logic [COUNT_W-1:0] MAX_BITS = 4'd8;

  // pending child slot stack
  localparam int SLOT_DEPTH = 256;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int SP_W       = SLOT_AW + 1;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int CNT_W   = Q_AW + 1;

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_TREE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CODE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_SYMBOL = 2'd0,
    ST_READY  = 2'd1,
    ST_ERROR  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_TREE,
    OP_CODE,
    OP_CLEAR,
    OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ATTACH,
    S_PUSH,
    S_WALK,
    S_FLUSH,
    S_ROOT
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SYM_W-1:0]   value;
    logic [COUNT_W-1:0] bit_count;
  } in_word_t;

  typedef struct packed {
    logic [SYM_W-1:0]    symbol;
    logic [STATUS_W-1:0] status;
    logic                last;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t                op;
    logic [SYM_W-1:0]   value;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  function automatic out_word_t make_word(input logic [SYM_W-1:0] sym,
                                          input status_t st,
                                          input logic lst);
    out_word_t w;
    w.symbol = sym;
    w.status = st;
    w.last   = lst;
    return w;
  endfunction

endpackage

// ===== hdl/hft_ram.sv =====
module hft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/hft_front.sv =====
module hft_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  hft_pkg::in_word_t in_word,
  output logic             busy,
  output logic             cmd_valid,
  output hft_pkg::cmd_t    cmd,
  input  logic             cmd_pop
);

  import hft_pkg::*;

  cmd_t             q_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t             cls;
  logic             push, pop;

  // classify the incoming word
  always_comb begin
    cls.value = in_word.value;
    if (in_word.bit_count > MAX_BITS) begin
      cls.count = MAX_BITS;
    end else begin
      cls.count = in_word.bit_count;
    end
    unique case (in_word.kind)
      KIND_TREE:  cls.op = OP_TREE;
      KIND_CODE:  cls.op = OP_CODE;
      KIND_CLEAR: cls.op = OP_CLEAR;
      KIND_BAD:   cls.op = OP_BAD;
    endcase
  end

  assign busy      = (cnt_r == CNT_W'(Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = start && !busy;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_AW'(push);
    rd_ptr_nxt = rd_ptr_r + Q_AW'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== hdl/hft_back.sv =====
module hft_back #(
  parameter int MAX_NODES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  hft_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               out_strobe,
  output hft_pkg::out_word_t out_word
);

  import hft_pkg::*;

  localparam int NW      = $clog2(MAX_NODES);
  localparam int NC_W    = $clog2(MAX_NODES + 1);
  localparam int CHILD_W = 1 + SYM_W + NW;
  localparam int SLOT_W  = NW + 1;

  state_t             state_r, state_nxt;
  logic [NC_W-1:0]    nc_r, nc_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic               await_r, await_nxt;
  logic               ready_r, ready_nxt;
  logic [NW-1:0]      walk_r, walk_nxt;
  logic               root_leaf_r, root_leaf_nxt;
  logic [SYM_W-1:0]   root_sym_r, root_sym_nxt;
  logic               cur_leaf_r, cur_leaf_nxt;
  logic [SYM_W-1:0]   cur_sym_r, cur_sym_nxt;
  logic [NW-1:0]      new_idx_r, new_idx_nxt;
  logic [SLOT_AW-1:0] push_addr_r, push_addr_nxt;
  logic [SYM_W-1:0]   bits_r, bits_nxt;
  logic [COUNT_W-1:0] left_r, left_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [SYM_W-1:0]   pend_sym_r, pend_sym_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  out_word_t          out_word_r, out_word_nxt;

  // memory ports
  logic [NW-1:0]      rd_addr;
  logic [CHILD_W-1:0] left_rdata, right_rdata, child_wdata, walk_entry;
  logic [NW-1:0]      child_waddr;
  logic               lw_we, rw_we;
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
  logic [SLOT_W-1:0]  slot_wdata, slot_rdata;
  logic [SP_W-1:0]    sp_dec;
  logic               c_leaf;
  logic [SYM_W-1:0]   c_sym;
  logic [NW-1:0]      c_idx;
  logic               tree_err, node_full, slot_full;

  // child tables: each entry holds the child's index plus its leaf flag and symbol,
  // so one read per code bit is enough
  hft_ram #(.WIDTH(CHILD_W), .DEPTH(MAX_NODES)) u_left (
    .clk   (clk),
    .we    (lw_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .raddr (rd_addr),
    .rdata (left_rdata)
  );

  hft_ram #(.WIDTH(CHILD_W), .DEPTH(MAX_NODES)) u_right (
    .clk   (clk),
    .we    (rw_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .raddr (rd_addr),
    .rdata (right_rdata)
  );

  hft_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_DEPTH)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  assign sp_dec     = sp_r - SP_W'(1);
  assign slot_raddr = sp_dec[SLOT_AW-1:0];
  assign walk_entry = bits_r[SYM_W-1] ? right_rdata : left_rdata;
  assign c_leaf     = walk_entry[CHILD_W-1];
  assign c_sym      = walk_entry[CHILD_W-2 -: SYM_W];
  assign c_idx      = walk_entry[NW-1:0];
  assign tree_err   = ready_r || ((nc_r != '0) && (sp_r == '0));
  assign node_full  = (nc_r >= NC_W'(MAX_NODES));
  assign slot_full  = (nc_r != '0) && (sp_r == SP_W'(SLOT_DEPTH));

  always_comb begin
    state_nxt      = state_r;
    nc_nxt         = nc_r;
    sp_nxt         = sp_r;
    await_nxt      = await_r;
    ready_nxt      = ready_r;
    walk_nxt       = walk_r;
    root_leaf_nxt  = root_leaf_r;
    root_sym_nxt   = root_sym_r;
    cur_leaf_nxt   = cur_leaf_r;
    cur_sym_nxt    = cur_sym_r;
    new_idx_nxt    = new_idx_r;
    push_addr_nxt  = push_addr_r;
    bits_nxt       = bits_r;
    left_nxt       = left_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    cmd_pop        = 1'b0;
    rd_addr        = walk_r;
    child_waddr    = slot_rdata[SLOT_W-1:1];
    child_wdata    = {cur_leaf_r, cur_sym_r, new_idx_r};
    lw_we          = 1'b0;
    rw_we          = 1'b0;
    slot_we        = 1'b0;
    slot_waddr     = '0;
    slot_wdata     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_CLEAR: begin
              nc_nxt         = '0;
              sp_nxt         = '0;
              await_nxt      = 1'b0;
              ready_nxt      = 1'b0;
              walk_nxt       = '0;
              root_leaf_nxt  = 1'b0;
              pend_valid_nxt = 1'b0;
            end
            OP_BAD: begin
              out_strobe_nxt = 1'b1;
              out_word_nxt   = make_word('0, ST_ERROR, 1'b1);
            end
            OP_CODE: begin
              if (!ready_r) begin
                out_strobe_nxt = 1'b1;
                out_word_nxt   = make_word('0, ST_ERROR, 1'b1);
              end else if (cmd.count != '0) begin
                bits_nxt  = cmd.value;
                left_nxt  = cmd.count;
                state_nxt = root_leaf_r ? S_ROOT : S_WALK;
              end
            end
            OP_TREE: begin
              if (tree_err) begin
                out_strobe_nxt = 1'b1;
                out_word_nxt   = make_word('0, ST_ERROR, 1'b1);
              end else if (await_r) begin
                if (nc_r == '0) begin
                  // the whole tree is one leaf
                  root_leaf_nxt  = 1'b1;
                  root_sym_nxt   = cmd.value;
                  nc_nxt         = NC_W'(1);
                  await_nxt      = 1'b0;
                  ready_nxt      = 1'b1;
                  walk_nxt       = '0;
                  out_strobe_nxt = 1'b1;
                  out_word_nxt   = make_word('0, ST_READY, 1'b1);
                end else begin
                  cur_leaf_nxt = 1'b1;
                  cur_sym_nxt  = cmd.value;
                  new_idx_nxt  = nc_r[NW-1:0];
                  state_nxt    = S_ATTACH;
                end
              end else if (node_full) begin
                out_strobe_nxt = 1'b1;
                out_word_nxt   = make_word('0, ST_ERROR, 1'b1);
              end else if (cmd.value == LEAF_MARK) begin
                await_nxt = 1'b1;
              end else if (slot_full) begin
                out_strobe_nxt = 1'b1;
                out_word_nxt   = make_word('0, ST_ERROR, 1'b1);
              end else if (nc_r == '0) begin
                // internal root: push its right then left slot
                root_leaf_nxt = 1'b0;
                new_idx_nxt   = '0;
                slot_we       = 1'b1;
                slot_waddr    = '0;
                slot_wdata    = {{NW{1'b0}}, 1'b1};
                push_addr_nxt = SLOT_AW'(1);
                state_nxt     = S_PUSH;
              end else begin
                cur_leaf_nxt = 1'b0;
                cur_sym_nxt  = '0;
                new_idx_nxt  = nc_r[NW-1:0];
                state_nxt    = S_ATTACH;
              end
            end
          endcase
        end
      end

      S_ATTACH: begin
        // top slot read is back: link the new node into its parent
        lw_we = !slot_rdata[0];
        rw_we = slot_rdata[0];
        if (cur_leaf_r) begin
          sp_nxt    = sp_dec;
          nc_nxt    = nc_r + NC_W'(1);
          await_nxt = 1'b0;
          state_nxt = S_IDLE;
          if (sp_dec == '0) begin
            ready_nxt      = 1'b1;
            walk_nxt       = '0;
            out_strobe_nxt = 1'b1;
            out_word_nxt   = make_word('0, ST_READY, 1'b1);
          end
        end else begin
          slot_we       = 1'b1;
          slot_waddr    = sp_dec[SLOT_AW-1:0];
          slot_wdata    = {new_idx_r, 1'b1};
          push_addr_nxt = sp_r[SLOT_AW-1:0];
          state_nxt     = S_PUSH;
        end
      end

      S_PUSH: begin
        slot_we    = 1'b1;
        slot_waddr = push_addr_r;
        slot_wdata = {new_idx_r, 1'b0};
        sp_nxt     = SP_W'(push_addr_r) + SP_W'(1);
        nc_nxt     = nc_r + NC_W'(1);
        state_nxt  = S_IDLE;
      end

      S_WALK: begin
        walk_nxt = c_leaf ? '0 : c_idx;
        rd_addr  = walk_nxt;
        if (c_leaf) begin
          // hold each symbol one step so the final one can carry last
          if (pend_valid_r) begin
            out_strobe_nxt = 1'b1;
            out_word_nxt   = make_word(pend_sym_r, ST_SYMBOL, 1'b0);
          end
          pend_valid_nxt = 1'b1;
          pend_sym_nxt   = c_sym;
        end
        bits_nxt = {bits_r[SYM_W-2:0], 1'b0};
        left_nxt = left_r - COUNT_W'(1);
        if (left_r == COUNT_W'(1)) begin
          state_nxt = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (pend_valid_r) begin
          out_strobe_nxt = 1'b1;
          out_word_nxt   = make_word(pend_sym_r, ST_SYMBOL, 1'b1);
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end

      S_ROOT: begin
        out_strobe_nxt = 1'b1;
        out_word_nxt   = make_word(root_sym_r, ST_SYMBOL, left_r == COUNT_W'(1));
        left_nxt       = left_r - COUNT_W'(1);
        if (left_r == COUNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      nc_r         <= '0;
      sp_r         <= '0;
      await_r      <= 1'b0;
      ready_r      <= 1'b0;
      walk_r       <= '0;
      root_leaf_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nc_r         <= nc_nxt;
      sp_r         <= sp_nxt;
      await_r      <= await_nxt;
      ready_r      <= ready_nxt;
      walk_r       <= walk_nxt;
      root_leaf_r  <= root_leaf_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    root_sym_r  <= root_sym_nxt;
    cur_leaf_r  <= cur_leaf_nxt;
    cur_sym_r   <= cur_sym_nxt;
    new_idx_r   <= new_idx_nxt;
    push_addr_r <= push_addr_nxt;
    bits_r      <= bits_nxt;
    left_r      <= left_nxt;
    pend_sym_r  <= pend_sym_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

`ifndef SYNTHESIS
  a_walk_needs_tree: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (ready_r && !root_leaf_r))
    else $error("tree walk without a complete internal tree");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (out_word_r.status != ST_SYMBOL)) |-> out_word_r.last)
    else $error("status word not marked last");

  a_ready_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (out_word_r.status == ST_READY)) |-> (ready_r && !await_r))
    else $error("tree complete reported without ready state");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |=> !pend_valid_r)
    else $error("held symbol survives flush");

  a_leaf_room: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (nc_r < NC_W'(MAX_NODES)))
    else $error("leaf symbol expected with node table full");
`endif

endmodule

// ===== hdl/huffman_tree_load_and_decode_top.sv =====
// channel  | ports                    | handshake
// ---------+--------------------------+----------------------------------------------
// input    | start, busy, in_word     | word taken at a clock edge with start high and
//          |                          | busy low
// result   | out_strobe, out_word     | word valid for one cycle while out_strobe is
//          |                          | high, taken at the edge that ends that cycle
//
// a two-entry command queue sits between the front (accept, classify) and the back
// (tree build and walk); busy is high only while that queue is full
// code word: the back reads one child-table entry per bit, then flushes the held symbol
// single-leaf tree: the root symbol once per code bit; tree byte: slot pop, up to two pushes
// reset: synchronous active-low rst_n clears control state; the tables need no
// clearing pass, entries are written before they are read
// the receiver cannot stall: each result word shows for exactly one cycle
module huffman_tree_load_and_decode_top #(
  parameter int MAX_NODES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hft_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output hft_pkg::out_word_t out_word
);

  import hft_pkg::*;

  // front to back command path
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front: takes input words, maps kind to an op, clamps the bit count, queues them
  hft_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: builds the tree from preorder bytes on a slot stack, walks it for code bits
  hft_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

// ===== tb/sv/huffman_decode_checker.sv =====
`timescale 1ns / 100ps

// watches both channels, predicts every result word and compares in order
module huffman_decode_checker #(
  parameter int MAX_NODES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  hft_pkg::in_word_t  in_word,
  input  logic               out_strobe,
  input  hft_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending
);

  import hft_pkg::*;

  // node entry: leaf flag, symbol, left child, right child
  logic [26:0] node_mem [MAX_NODES];
  logic [9:0]  node_total;
  // open child slots: node index and side, side 1 is right
  logic [9:0]  slot_mem [SLOT_DEPTH];
  logic [8:0]  slot_top;
  logic        leaf_pending;
  logic        tree_done;
  logic [8:0]  walk_pos;

  out_word_t expected_words [$];
  int        result_index;

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, result_index, msg);
    fail_count++;
  endtask

  task automatic clear_tree();
    node_total   = '0;
    slot_top     = '0;
    leaf_pending = 1'b0;
    tree_done    = 1'b0;
    walk_pos     = '0;
  endtask

  task automatic emit(input logic [7:0] sym, input status_t st);
    out_word_t o;
    o.symbol = sym;
    o.status = st;
    o.last   = 1'b0;
    expected_words.push_back(o);
  endtask

  // hang node n on the slot at the top of the stack
  task automatic link_child(input logic [8:0] n);
    logic [9:0]  s;
    logic [26:0] parent;
    if (node_total == 0 || slot_top == 0) return;
    slot_top = slot_top - 9'd1;
    s = slot_mem[slot_top[7:0]];
    parent = node_mem[s[9:1]];
    if (s[0]) parent[8:0] = n;
    else parent[17:9] = n;
    node_mem[s[9:1]] = parent;
  endtask

  task automatic load_tree_byte(input logic [7:0] v);
    logic [8:0] n;
    int         depth;
    if (tree_done || (node_total != 0 && slot_top == 0)) begin
      emit(8'h00, ST_ERROR);
      return;
    end
    n = node_total[8:0];
    if (leaf_pending) begin
      node_mem[n] = {1'b1, v, 18'd0};
      link_child(n);
      node_total   = node_total + 10'd1;
      leaf_pending = 1'b0;
      if (slot_top == 0) begin
        tree_done = 1'b1;
        walk_pos  = '0;
        emit(8'h00, ST_READY);
      end
      return;
    end
    if (node_total >= MAX_NODES) begin
      emit(8'h00, ST_ERROR);
      return;
    end
    if (v == LEAF_MARK) begin
      leaf_pending = 1'b1;
      return;
    end
    depth = (node_total == 0) ? 2 : int'(slot_top) + 1;
    if (depth > SLOT_DEPTH) begin
      emit(8'h00, ST_ERROR);
      return;
    end
    node_mem[n] = '0;
    link_child(n);
    slot_mem[slot_top[7:0]] = {n, 1'b1};
    slot_top = slot_top + 9'd1;
    slot_mem[slot_top[7:0]] = {n, 1'b0};
    slot_top = slot_top + 9'd1;
    node_total = node_total + 10'd1;
  endtask

  task automatic walk_code_bits(input logic [7:0] v, input logic [3:0] count);
    int          nbits;
    int          i;
    logic        code_bit;
    logic [26:0] cur;
    if (!tree_done) begin
      emit(8'h00, ST_ERROR);
      return;
    end
    nbits = (count > MAX_BITS) ? int'(MAX_BITS) : int'(count);
    for (i = 0; i < nbits; i++) begin
      code_bit = v[7-i];
      if (node_mem[0][26]) begin
        // lone root leaf: one symbol per bit
        emit(node_mem[0][25:18], ST_SYMBOL);
      end else begin
        cur = node_mem[walk_pos];
        walk_pos = code_bit ? cur[8:0] : cur[17:9];
        if (node_mem[walk_pos][26]) begin
          emit(node_mem[walk_pos][25:18], ST_SYMBOL);
          walk_pos = '0;
        end
      end
    end
  endtask

  task automatic predict_results(input in_word_t w);
    int        before_cnt;
    out_word_t tail;
    before_cnt = expected_words.size();
    case (w.kind)
      KIND_TREE:  load_tree_byte(w.value);
      KIND_CODE:  walk_code_bits(w.value, w.bit_count);
      KIND_CLEAR: clear_tree();
      default:    emit(8'h00, ST_ERROR);
    endcase
    if (expected_words.size() > before_cnt) begin
      tail = expected_words.pop_back();
      tail.last = 1'b1;
      expected_words.push_back(tail);
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word with none expected: symbol %02h status %0d last %0b",
                                got.symbol, got.status, got.last));
    end else begin
      want = expected_words.pop_front();
      if (got.symbol !== want.symbol)
        report_mismatch($sformatf("symbol %02h, expected %02h", got.symbol, want.symbol));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    end
    result_index++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tree();
      expected_words.delete();
      fail_count   = 0;
      result_index = 0;
    end else begin
      if (start && !busy) predict_results(in_word);
      if (out_strobe) check_result(out_word);
    end
    pending <= expected_words.size();
  end

endmodule

// ===== tb/sv/huffman_tree_load_and_decode_top_tb.sv =====
`timescale 1ns / 100ps

module huffman_tree_load_and_decode_top_tb;
  import hft_pkg::*;

  localparam int MAX_NODES   = 512;
  localparam int CLK_PERIOD  = 10;
  // tail for the longest code word in the back, behind a two-deep queue
  localparam int DRAIN_CYCLES = 40;
  // ~130 words, with room to spare even with long sender gaps
  localparam int CYCLE_LIMIT = 200000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_strobe;
  out_word_t out_word;

  int fail_count;
  int pending;
  int idle_pct;
  int word_total;
  int cycle_count;

  huffman_tree_load_and_decode_top #(
    .MAX_NODES(MAX_NODES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  // prediction and comparison live in the checker, the top only drives
  huffman_decode_checker #(
    .MAX_NODES(MAX_NODES)
  ) i_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // hard stop in case the block hangs or never drains
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // one word on the input channel; called and returning at a falling edge
  // start stays high on return so back-to-back words need no extra edge
  task automatic send_word(input logic [KIND_W-1:0] k, input logic [7:0] v,
                           input logic [COUNT_W-1:0] c);
    in_word_t w;
    w.kind      = k;
    w.value     = v;
    w.bit_count = c;
    // random sender gap, each idle step lowers start exactly once
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    // busy is read at the rising edge, before the block updates it
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    word_total++;
  endtask

  // stop feeding until every predicted result word has come out
  task automatic hold_until_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_symbol();
    case ($urandom_range(7))
      0:       return LEAF_MARK;
      1:       return 8'h00;
      2:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // internal node byte: anything but the leaf marker
  function automatic logic [7:0] random_inner();
    logic [7:0] v;
    v = 8'($urandom);
    while (v == LEAF_MARK) v = 8'($urandom);
    return v;
  endfunction

  // mostly legal bit counts, now and then zero or above eight
  function automatic logic [3:0] random_count();
    if ($urandom_range(9) != 0) return 4'($urandom_range(1, 8));
    if ($urandom_range(1) == 0) return 4'd0;
    return 4'($urandom_range(9, 15));
  endfunction

  // random full binary tree in preorder, cut short after cut nodes when cut > 0
  task automatic send_tree(input int leaves, input int cut);
    int open_slots;
    int inner_left;
    int node_cnt;
    open_slots = 1;
    inner_left = leaves - 1;
    node_cnt   = 0;
    while (open_slots > 0 && (cut == 0 || node_cnt < cut)) begin
      // an internal node is forced while only one slot is open and internal nodes remain
      if (inner_left > 0 && (open_slots == 1 || $urandom_range(1) == 1)) begin
        send_word(KIND_TREE, random_inner(), 4'($urandom));
        inner_left--;
        open_slots++;
      end else begin
        send_word(KIND_TREE, LEAF_MARK, 4'($urandom));
        send_word(KIND_TREE, random_symbol(), 4'($urandom));
        open_slots--;
      end
      node_cnt++;
    end
  endtask

  task automatic send_code();
    send_word(KIND_CODE, 8'($urandom), random_count());
  endtask

  // any kind, any value, any count
  task automatic send_noise();
    send_word(2'($urandom), 8'($urandom), 4'($urandom));
  endtask

  // a clear, a tree and a burst of code words; some episodes are broken on purpose
  task automatic run_episode(input bit force_hold);
    int mode;
    int leaves;
    int words;
    mode = $urandom_range(9);
    leaves = (mode == 0) ? $urandom_range(10, 16) : $urandom_range(1, 9);
    send_word(KIND_CLEAR, 8'($urandom), 4'($urandom));
    if (mode == 1) begin
      // tree never completes: code words must be refused
      if (leaves < 2) leaves = 2;
      send_tree(leaves, $urandom_range(1, 2 * leaves - 2));
      if ($urandom_range(1) == 0) send_word(KIND_TREE, LEAF_MARK, 4'($urandom));
    end else begin
      send_tree(leaves, 0);
    end
    words = $urandom_range(2, 8);
    repeat (words) begin
      if (mode == 2 && $urandom_range(3) == 0) send_noise();
      else send_code();
    end
    // stray tree byte once the tree is done
    if (mode == 4) send_word(KIND_TREE, 8'($urandom), 4'($urandom));
    if (mode == 3 || force_hold) hold_until_drained();
  endtask

  initial begin
    int target;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_word    = '0;
    idle_pct   = 13;
    word_total = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: order errors, lone leaf tree, bit count edges
    send_word(KIND_CODE, 8'hA5, 4'd8);        // code before any tree
    send_word(KIND_BAD, 8'hFF, 4'hF);         // unknown kind
    send_word(KIND_TREE, LEAF_MARK, 4'd0);    // lone root leaf
    send_word(KIND_TREE, 8'h00, 4'd0);
    send_word(KIND_CODE, 8'hFF, 4'd8);        // eight copies of the root symbol
    send_word(KIND_CODE, 8'hFF, 4'd0);        // no bits, no result
    send_word(KIND_CODE, 8'h5A, 4'd15);       // count clipped to eight
    send_word(KIND_TREE, 8'h7E, 4'd0);        // tree byte after completion
    send_word(KIND_CLEAR, 8'h00, 4'd0);

    // three leaves: left-left, left-right, right (the marker itself as symbol)
    send_word(KIND_TREE, 8'hFF, 4'd0);
    send_word(KIND_TREE, 8'h00, 4'd0);
    send_word(KIND_TREE, LEAF_MARK, 4'd0);
    send_word(KIND_TREE, 8'h41, 4'd0);
    send_word(KIND_TREE, LEAF_MARK, 4'd0);
    send_word(KIND_TREE, 8'hFF, 4'd0);
    send_word(KIND_TREE, LEAF_MARK, 4'd0);
    send_word(KIND_TREE, LEAF_MARK, 4'd0);
    send_word(KIND_CODE, 8'b0001_1000, 4'd5); // three symbols from one word
    send_word(KIND_CODE, 8'b0000_0000, 4'd1); // walk stops mid tree
    send_word(KIND_CODE, 8'b1000_0000, 4'd1); // and resumes in the next word
    hold_until_drained();

    // random: sender gaps at 13 percent, then 52, then none
    target = word_total + 25;
    run_episode(1'b1);
    while (word_total < target) run_episode(1'b0);
    idle_pct = 52;
    target = word_total + 25;
    while (word_total < target) run_episode(1'b0);
    idle_pct = 0;
    target = word_total + 25;
    while (word_total < target) run_episode(1'b0);

    // wait out the last words, then a tail for anything stray
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hft_pkg.sv
hdl/hft_ram.sv
hdl/hft_front.sv
hdl/hft_back.sv
hdl/huffman_tree_load_and_decode_top.sv
tb/sv/huffman_decode_checker.sv
tb/sv/huffman_tree_load_and_decode_top_tb.sv
